FILE: rtl/fdss_pkg.sv
// ----------------------------------------------------------------------------
// fdss_pkg
// Shared widths, constants and conversion functions for the four-digit
// segment scan core.
// ----------------------------------------------------------------------------
package fdss_pkg;

    localparam int VALUE_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int DIGIT_COUNT_DEF = 4;

    localparam logic [BYTE_W-1:0] GHOST_ON  = 8'hFF;
    localparam logic [BYTE_W-1:0] GHOST_OFF = 8'h00;
    localparam logic [BYTE_W-1:0] SEG_BLANK = 8'hFF;

    localparam logic [1:0] BEAT_GHOST_ON  = 2'd0;
    localparam logic [1:0] BEAT_GHOST_OFF = 2'd1;
    localparam logic [1:0] BEAT_SEG       = 2'd2;
    localparam logic [1:0] BEAT_SEL       = 2'd3;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [BYTE_W-1:0] low;
    } t_part;

    function automatic logic [BYTE_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [BYTE_W-1:0] seg;
        case (digit)
            4'd0: seg = 8'b11000000;
            4'd1: seg = 8'b11111001;
            4'd2: seg = 8'b10100100;
            4'd3: seg = 8'b10110000;
            4'd4: seg = 8'b10011001;
            4'd5: seg = 8'b10010010;
            4'd6: seg = 8'b10000010;
            4'd7: seg = 8'b11111000;
            4'd8: seg = 8'b10000000;
            4'd9: seg = 8'b10010000;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // Eight shift-and-add-3 steps of a binary to BCD conversion.
    function automatic logic [BCD_W-1:0] dd_byte(input logic [BCD_W-1:0] bcd_in,
                                                 input logic [BYTE_W-1:0] chunk);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int s = 0; s < BYTE_W; s++) begin
            for (int n = 0; n < BCD_DIGITS; n++) begin
                if (acc[n*4 +: 4] >= 4'd5) begin
                    acc[n*4 +: 4] = acc[n*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], chunk[BYTE_W-1-s]};
        end
        return acc;
    endfunction

endpackage

FILE: rtl/fdss_convert.sv
// ----------------------------------------------------------------------------
// fdss_convert
// Input register, scan position counter and the first half of the
// binary to BCD conversion.
// ----------------------------------------------------------------------------
module fdss_convert #(
    parameter int DIGIT_COUNT = fdss_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [fdss_pkg::VALUE_W-1:0]        i_value,
    output logic                                o_ready,
    output logic                                o_valid,
    output fdss_pkg::t_part                     o_part,
    output logic [$clog2(DIGIT_COUNT)-1:0]      o_pos,
    input  logic                                i_ready
);

    localparam int POS_W = $clog2(DIGIT_COUNT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    logic                          r_s1_valid;
    logic [fdss_pkg::VALUE_W-1:0]  r_s1_value;
    logic [POS_W-1:0]              r_s1_pos;
    logic                          r_s2_valid;
    fdss_pkg::t_part               r_s2_part;
    logic [POS_W-1:0]              r_s2_pos;
    logic [POS_W-1:0]              r_scan_pos;
    logic [POS_W-1:0]              n_scan_pos;
    logic                          s2_open;
    logic                          s1_open;

    assign s2_open    = !r_s2_valid || i_ready;
    assign s1_open    = !r_s1_valid || s2_open;
    assign n_scan_pos = (r_scan_pos == POS_LAST) ? '0 : r_scan_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_scan_pos <= '0;
        end else begin
            if (s1_open) begin
                r_s1_valid <= i_valid;
            end
            if (s2_open) begin
                r_s2_valid <= r_s1_valid;
            end
            if (i_valid && s1_open) begin
                r_scan_pos <= n_scan_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && s1_open) begin
            r_s1_value <= i_value;
            r_s1_pos   <= r_scan_pos;
        end
        if (r_s1_valid && s2_open) begin
            r_s2_part.bcd <= fdss_pkg::dd_byte('0, r_s1_value[15:8]);
            r_s2_part.low <= r_s1_value[7:0];
            r_s2_pos      <= r_s1_pos;
        end
    end

    assign o_ready = s1_open;
    assign o_valid = r_s2_valid;
    assign o_part  = r_s2_part;
    assign o_pos   = r_s2_pos;

endmodule

FILE: rtl/fdss_emit.sv
// ----------------------------------------------------------------------------
// fdss_emit
// Finishes the BCD conversion, picks the digit at the scan position with
// leading-zero blanking, and sends the four bytes of one refresh tick.
// ----------------------------------------------------------------------------
module fdss_emit #(
    parameter int DIGIT_COUNT = fdss_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  fdss_pkg::t_part                     i_part,
    input  logic [$clog2(DIGIT_COUNT)-1:0]      i_pos,
    output logic                                o_ready,
    output logic                                o_out_valid,
    output logic [fdss_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_out_latch,
    output logic                                o_out_last,
    input  logic                                i_out_ready
);

    localparam int POS_W = $clog2(DIGIT_COUNT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

    logic [fdss_pkg::BCD_W-1:0]   bcd;
    logic [3:0]                   digits [DIGIT_COUNT];
    logic [3:0]                   cur_digit;
    logic                         lead_nz;
    logic [fdss_pkg::BYTE_W-1:0]  seg;
    logic [fdss_pkg::BYTE_W-1:0]  sel;
    logic                         r_busy;
    logic [1:0]                   r_beat;
    logic [fdss_pkg::BYTE_W-1:0]  r_seg;
    logic [fdss_pkg::BYTE_W-1:0]  r_sel;
    logic                         beat_done;

    assign bcd = fdss_pkg::dd_byte(i_part.bcd, i_part.low);

    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
        if (DIGIT_COUNT - 1 - k < fdss_pkg::BCD_DIGITS) begin : g_live
            assign digits[k] = bcd[(DIGIT_COUNT-1-k)*4 +: 4];
        end else begin : g_zero
            assign digits[k] = 4'd0;
        end
    end

    always_comb begin
        lead_nz   = 1'b0;
        cur_digit = 4'd0;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            if (POS_W'(k) <= i_pos && digits[k] != 4'd0) begin
                lead_nz = 1'b1;
            end
            if (POS_W'(k) == i_pos) begin
                cur_digit = digits[k];
            end
        end
        seg = (lead_nz || i_pos == POS_LAST) ? fdss_pkg::seg_pattern(cur_digit)
                                             : fdss_pkg::SEG_BLANK;
        sel = fdss_pkg::BYTE_W'(1) << (POS_LAST - i_pos);
    end

    assign beat_done = r_busy && i_out_ready;
    assign o_ready   = !r_busy || (beat_done && r_beat == fdss_pkg::BEAT_SEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= fdss_pkg::BEAT_GHOST_ON;
        end else begin
            if (i_valid && o_ready) begin
                r_busy <= 1'b1;
                r_beat <= fdss_pkg::BEAT_GHOST_ON;
            end else if (beat_done) begin
                if (r_beat == fdss_pkg::BEAT_SEL) begin
                    r_busy <= 1'b0;
                end else begin
                    r_beat <= r_beat + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_seg <= seg;
            r_sel <= sel;
        end
    end

    always_comb begin
        case (r_beat)
            fdss_pkg::BEAT_GHOST_ON:  o_out_byte = fdss_pkg::GHOST_ON;
            fdss_pkg::BEAT_GHOST_OFF: o_out_byte = fdss_pkg::GHOST_OFF;
            fdss_pkg::BEAT_SEG:       o_out_byte = r_seg;
            fdss_pkg::BEAT_SEL:       o_out_byte = r_sel;
            default:                  o_out_byte = fdss_pkg::GHOST_ON;
        endcase
    end

    assign o_out_valid = r_busy;
    assign o_out_latch = (r_beat == fdss_pkg::BEAT_GHOST_OFF) || (r_beat == fdss_pkg::BEAT_SEL);
    assign o_out_last  = (r_beat == fdss_pkg::BEAT_SEL);

endmodule

FILE: rtl/four_digit_segment_scan_core.sv
// ----------------------------------------------------------------------------
// four_digit_segment_scan_core
// Multiplexed seven-segment refresh with leading-zero blanking: each input
// beat is one refresh tick, and four output bytes go to a shift-register chain.
//
// Channel   Direction  Payload
// s_axis    in         tdata[15:0] = value
// m_axis    out        tdata[7:0] = out_byte, tuser[0] = latch_pulse, tlast = last
//
// Every tick produces four output beats; the emitter takes a new tick when
// idle or as the last output beat of the previous tick is accepted.
// With an empty pipeline an input beat passes registers s1 and s2 and the
// emitter's busy register before the first output beat is valid.
// The output serializer sets the rate; a new tick enters while the previous
// one is still being sent. Reset is synchronous and clears the scan position.
// ----------------------------------------------------------------------------
module four_digit_segment_scan_core #(
    parameter int DIGIT_COUNT = fdss_pkg::DIGIT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [fdss_pkg::VALUE_W-1:0]      i_s_axis_tdata,   // [15:0] value
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [fdss_pkg::BYTE_W-1:0]       o_m_axis_tdata,   // [7:0] out_byte
    output logic                              o_m_axis_tuser,   // [0] latch_pulse
    output logic                              o_m_axis_tlast
);

    logic                              conv_valid;
    fdss_pkg::t_part                   conv_part;
    logic [$clog2(DIGIT_COUNT)-1:0]    conv_pos;
    logic                              emit_ready;

    fdss_convert #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_convert (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_value (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .o_valid (conv_valid),
        .o_part  (conv_part),
        .o_pos   (conv_pos),
        .i_ready (emit_ready)
    );

    fdss_emit #(
        .DIGIT_COUNT(DIGIT_COUNT)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (conv_valid),
        .i_part      (conv_part),
        .i_pos       (conv_pos),
        .o_ready     (emit_ready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_latch (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .i_out_ready (i_m_axis_tready)
    );

endmodule
